// ===== sv/ecv_pkg.sv =====
// Shared constants, curve codes and pipeline control type for the easing curve evaluator.
// No dependencies; compiled first.
package ecv_pkg;

  localparam int ECV_FRACTION_BITS    = 16;
  localparam int ECV_SINE_TABLE_DEPTH = 256;

  // Number of register stages, output register included
  localparam int NUM_STAGES = 5;

  // pi/2 in Q60, seed for the quarter-wave table
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  localparam logic [2:0] STYLE_LINEAR      = 3'd0;
  localparam logic [2:0] STYLE_IN_SINE     = 3'd1;
  localparam logic [2:0] STYLE_OUT_SINE    = 3'd2;
  localparam logic [2:0] STYLE_INOUT_SINE  = 3'd3;
  localparam logic [2:0] STYLE_IN_QUAD     = 3'd4;
  localparam logic [2:0] STYLE_INOUT_QUAD  = 3'd5;
  localparam logic [2:0] STYLE_IN_CUBIC    = 3'd6;
  localparam logic [2:0] STYLE_OUT_QUAD    = 3'd7;

  typedef struct packed {
    logic [NUM_STAGES-1:0] vld;  // stage holds an item
    logic [NUM_STAGES-1:0] adv;  // stage register loads this cycle
  } pipe_ctl_t;

endpackage

// ===== sv/ecv_if.sv =====
// Valid/ready channel interfaces for progress items and eased results.
// Depends on ecv_pkg for the default fraction width.
interface ecv_in_if import ecv_pkg::*; #(
  parameter int FRACTION_BITS = ECV_FRACTION_BITS
);
  logic                     valid;
  logic                     ready;
  logic [FRACTION_BITS:0]   progress;
  logic [2:0]               easing_style;

  modport source (output valid, output progress, output easing_style, input ready);
  modport sink   (input valid, input progress, input easing_style, output ready);
endinterface

interface ecv_out_if import ecv_pkg::*; #(
  parameter int FRACTION_BITS = ECV_FRACTION_BITS
);
  logic                     valid;
  logic                     ready;
  logic [FRACTION_BITS:0]   eased_value;

  modport source (output valid, output eased_value, input ready);
  modport sink   (input valid, input eased_value, output ready);
endinterface

// ===== sv/ecv_sine_rom.sv =====
// Quarter-wave sine table, built at elaboration, with two registered read ports.
// Depends on ecv_pkg for the pi/2 constant.
module ecv_sine_rom import ecv_pkg::*; #(
  parameter int FRACTION_BITS    = ECV_FRACTION_BITS,
  parameter int SINE_TABLE_DEPTH = ECV_SINE_TABLE_DEPTH
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]      idx,
  output logic [FRACTION_BITS:0]                     lo,
  output logic [FRACTION_BITS:0]                     hi
);

  localparam int W    = FRACTION_BITS + 1;
  localparam int IDXW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [63:0] ONE64 = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] RND64 = 64'd1 << (59 - FRACTION_BITS);

  typedef logic [W-1:0] rom_t [0:SINE_TABLE_DEPTH];

  // floor(a*b / 2^60)
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Taylor series of sin, 13 terms, rounded and kept monotonic
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] qs, rs, x, x2, term, sum, v, prev;
    qs   = HALF_PI_Q60 / SINE_TABLE_DEPTH;
    rs   = HALF_PI_Q60 % SINE_TABLE_DEPTH;
    prev = 64'd0;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = qs * 64'(k) + (rs * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      term = mul_q60(term, x2) / 64'd6;   sum = sum - term;
      term = mul_q60(term, x2) / 64'd20;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd42;  sum = sum - term;
      term = mul_q60(term, x2) / 64'd72;  sum = sum + term;
      term = mul_q60(term, x2) / 64'd110; sum = sum - term;
      term = mul_q60(term, x2) / 64'd156; sum = sum + term;
      term = mul_q60(term, x2) / 64'd210; sum = sum - term;
      term = mul_q60(term, x2) / 64'd272; sum = sum + term;
      term = mul_q60(term, x2) / 64'd342; sum = sum - term;
      term = mul_q60(term, x2) / 64'd420; sum = sum + term;
      term = mul_q60(term, x2) / 64'd506; sum = sum - term;
      term = mul_q60(term, x2) / 64'd600; sum = sum + term;
      v = (sum + RND64) >> (60 - FRACTION_BITS);
      if (v > ONE64) begin
        v = ONE64;
      end
      if (v < prev) begin
        v = prev;
      end
      prev   = v;
      rom[k] = v[W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [IDXW-1:0] idx_hi;

  assign idx_hi = (idx == IDXW'(SINE_TABLE_DEPTH)) ? idx : IDXW'(idx + 1'b1);

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= ROM[idx];
      hi <= ROM[idx_hi];
    end
  end

endmodule

// ===== sv/ecv_pipe_ctl.sv =====
// Valid tracking and per-stage load enables; a stage loads when empty or draining.
// Depends on ecv_pkg for the stage count and control struct.
module ecv_pipe_ctl import ecv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output pipe_ctl_t ctl
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign ctl.vld = vld;
  assign ctl.adv = adv;

endmodule

// ===== sv/easing_curve_evaluator_top.sv =====
// Top level of the easing curve evaluator: five-stage datapath around the sine table.
// Depends on ecv_pkg, ecv_if, ecv_sine_rom and ecv_pipe_ctl.

// Maps a progress value (unsigned Q1.FRACTION_BITS, above 1.0 saturates) to an
// eased value in the same format through one of eight curves chosen per item.
// One item is accepted every clock cycle unless a stalled output backs up to the input.
// Each item passes through five register stages, the first loaded at the input transfer,
// which hold the chain of multipliers (table position, square, cube, interpolation) and
// the registered table read.
// Stalls on the output fill empty stages first, so up to five items can be held.
// The sine table is a constant; there is no start-up pass after reset.
module easing_curve_evaluator_top import ecv_pkg::*; #(
  parameter int FRACTION_BITS    = ECV_FRACTION_BITS,
  parameter int SINE_TABLE_DEPTH = ECV_SINE_TABLE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  ecv_in_if.sink     din,
  ecv_out_if.source  dout
);

  localparam int W    = FRACTION_BITS + 1;
  localparam int IDXW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW   = W + IDXW;
  localparam logic [W-1:0]   ONE      = W'(1) << FRACTION_BITS;
  localparam logic [W-1:0]   HALF_ONE = W'(1) << (FRACTION_BITS - 1);
  localparam logic [W:0]     ONE_X    = (W+1)'(1) << FRACTION_BITS;

  pipe_ctl_t ctl;

  ecv_pipe_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .out_ready (dout.ready),
    .ctl       (ctl)
  );

  assign din.ready  = ctl.adv[0];
  assign dout.valid = ctl.vld[NUM_STAGES-1];

  // ---------------- stage 1: saturate, pick table phase and square operands
  logic [W-1:0] p_sat, q_in, phase_in, b_in;
  logic [W:0]   t2, a_in;
  logic         upper_in;

  logic [W-1:0] s1_p, s1_phase, s1_b;
  logic [W:0]   s1_a;
  logic [2:0]   s1_style;
  logic         s1_upper;

  always_comb begin
    p_sat = (din.progress > ONE) ? ONE : din.progress;
    q_in  = ONE - p_sat;
    t2    = {p_sat, 1'b0};
    case (din.easing_style)
      STYLE_IN_SINE:    phase_in = q_in;
      STYLE_INOUT_SINE: phase_in = (t2 > ONE_X) ? W'(t2 - ONE_X) : W'(ONE_X - t2);
      default:          phase_in = p_sat;
    endcase
    if (din.easing_style == STYLE_INOUT_SINE) begin
      upper_in = t2 > ONE_X;
    end else begin
      upper_in = p_sat >= HALF_ONE;
    end
    case (din.easing_style)
      STYLE_INOUT_QUAD: begin
        a_in = upper_in ? {q_in, 1'b0} : {p_sat, 1'b0};
        b_in = upper_in ? q_in : p_sat;
      end
      STYLE_OUT_QUAD: begin
        a_in = {1'b0, q_in};
        b_in = q_in;
      end
      default: begin
        a_in = {1'b0, p_sat};
        b_in = p_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      s1_p     <= p_sat;
      s1_phase <= phase_in;
      s1_a     <= a_in;
      s1_b     <= b_in;
      s1_style <= din.easing_style;
      s1_upper <= upper_in;
    end
  end

  // ---------------- stage 2: table position, rounded square
  logic [PW-1:0]    pos;
  logic [2*W:0]     sq_prod;
  logic [IDXW-1:0]  idx_c;
  logic [FRACTION_BITS-1:0] frac_c;

  logic [IDXW-1:0]  s2_idx;
  logic [FRACTION_BITS-1:0] s2_frac;
  logic [W-1:0]     s2_sq, s2_p;
  logic [2:0]       s2_style;
  logic             s2_upper;

  always_comb begin
    pos     = PW'(s1_phase) * PW'(SINE_TABLE_DEPTH);
    sq_prod = (2*W+1)'(s1_a) * (2*W+1)'(s1_b) + (2*W+1)'(HALF_ONE);
    // full quarter wave lands on the last entry
    if (s1_phase[FRACTION_BITS]) begin
      idx_c  = IDXW'(SINE_TABLE_DEPTH);
      frac_c = '0;
    end else begin
      idx_c  = pos[FRACTION_BITS +: IDXW];
      frac_c = pos[FRACTION_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      s2_idx   <= idx_c;
      s2_frac  <= frac_c;
      s2_sq    <= sq_prod[FRACTION_BITS +: W];
      s2_p     <= s1_p;
      s2_style <= s1_style;
      s2_upper <= s1_upper;
    end
  end

  // ---------------- stage 3: table read, raw cube
  logic [W-1:0]     s3_lo, s3_hi;
  logic [FRACTION_BITS-1:0] s3_frac;
  logic [2*W-1:0]   s3_cube;
  logic [W-1:0]     s3_sq, s3_p;
  logic [2:0]       s3_style;
  logic             s3_upper;

  ecv_sine_rom #(
    .FRACTION_BITS    (FRACTION_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk (clk),
    .en  (ctl.adv[2]),
    .idx (s2_idx),
    .lo  (s3_lo),
    .hi  (s3_hi)
  );

  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      s3_frac  <= s2_frac;
      s3_cube  <= (2*W)'(s2_sq) * (2*W)'(s2_p);
      s3_sq    <= s2_sq;
      s3_p     <= s2_p;
      s3_style <= s2_style;
      s3_upper <= s2_upper;
    end
  end

  // ---------------- stage 4: interpolation product, rounded cube
  logic [W-1:0]             diff;
  logic [2*W-1:0]           cube_rnd;
  logic [W+FRACTION_BITS-1:0] s4_ip;
  logic [W-1:0]             s4_lo, s4_cube, s4_sq, s4_p;
  logic [2:0]               s4_style;
  logic                     s4_upper;

  assign diff     = s3_hi - s3_lo;  // table is non-decreasing
  assign cube_rnd = s3_cube + (2*W)'(HALF_ONE);

  always_ff @(posedge clk) begin
    if (ctl.adv[3]) begin
      s4_ip    <= (W+FRACTION_BITS)'(diff) * (W+FRACTION_BITS)'(s3_frac);
      s4_lo    <= s3_lo;
      s4_cube  <= cube_rnd[FRACTION_BITS +: W];
      s4_sq    <= s3_sq;
      s4_p     <= s3_p;
      s4_style <= s3_style;
      s4_upper <= s3_upper;
    end
  end

  // ---------------- stage 5: sine value, curve select, clamp
  logic [W+FRACTION_BITS-1:0] ip_rnd;
  logic [W:0]   sine;
  logic [W+1:0] half_sum;
  logic [W:0]   res;

  always_comb begin
    ip_rnd = s4_ip + (W+FRACTION_BITS)'(HALF_ONE);
    sine   = (W+1)'(s4_lo) + (W+1)'(ip_rnd[FRACTION_BITS +: W]);
    if (s4_upper) begin
      half_sum = ((W+2)'(ONE) + (W+2)'(sine) + (W+2)'(1)) >> 1;
    end else begin
      half_sum = ((W+2)'(ONE) - (W+2)'(sine) + (W+2)'(1)) >> 1;
    end
    case (s4_style)
      STYLE_IN_SINE:    res = ONE_X - sine;
      STYLE_OUT_SINE:   res = sine;
      STYLE_INOUT_SINE: res = half_sum[W:0];
      STYLE_IN_QUAD:    res = (W+1)'(s4_sq);
      STYLE_INOUT_QUAD: res = s4_upper ? ONE_X - (W+1)'(s4_sq) : (W+1)'(s4_sq);
      STYLE_IN_CUBIC:   res = (W+1)'(s4_cube);
      STYLE_OUT_QUAD:   res = ONE_X - (W+1)'(s4_sq);
      default:          res = (W+1)'(s4_p);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[4]) begin
      dout.eased_value <= (res > ONE_X) ? ONE : res[W-1:0];
    end
  end

endmodule

// ===== sv/ecv_checker.sv =====
// Port-level checks for the easing curve evaluator, bound to the top level.
// Depends on ecv_pkg for the stage count.
module ecv_checker import ecv_pkg::*; #(
  parameter int FRACTION_BITS = ECV_FRACTION_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [FRACTION_BITS:0] eased_value
);

  localparam int CW = $clog2(NUM_STAGES + 2);
  localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

  logic          in_xfer, out_xfer;
  logic [CW-1:0] inflight;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight <= inflight + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      inflight <= inflight - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(eased_value))
    else $error("result dropped or changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> eased_value <= ONE)
    else $error("eased value above 1.0");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> inflight != '0)
    else $error("result transfer with no item in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(NUM_STAGES))
    else $error("more items in flight than pipeline stages");

endmodule

bind easing_curve_evaluator_top ecv_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_ecv_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (din.valid),
  .in_ready    (din.ready),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .eased_value (dout.eased_value)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for easing_curve_evaluator_top: directed table, then random items.
// Predicts eased values from its own sine table and curve arithmetic, or uses hand-worked ones; compares in order.
// Depends on ecv_pkg, ecv_if and the easing curve evaluator RTL.
module testbench;
  import ecv_pkg::*;

  localparam int FB    = ECV_FRACTION_BITS;
  localparam int DEPTH = ECV_SINE_TABLE_DEPTH;
  localparam bit [63:0] ONE      = 64'd1 << FB;
  localparam bit [63:0] HALF_LSB = 64'd1 << (FB - 1);

  localparam logic [FB:0] P_ONE     = ONE[FB:0];
  localparam logic [FB:0] P_HALF    = P_ONE >> 1;
  localparam logic [FB:0] P_QUARTER = P_ONE >> 2;
  localparam logic [FB:0] P_MAX     = '1;

  localparam int NUM_DIRECTED    = 25;
  localparam int ITEMS_PER_PHASE = 450;
  localparam int HOLD_CYCLES     = 150;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic [FB:0] progress;
    logic [2:0]  style;
    logic [FB:0] eased;
  } eased_check_t;

  typedef struct packed {
    logic [FB:0] progress;
    logic [2:0]  style;
    logic        typed;   // eased holds a hand-worked value
    logic [FB:0] eased;
  } curve_row_t;

  logic clk;
  logic rst;

  ecv_in_if  din_if ();
  ecv_out_if dout_if ();

  easing_curve_evaluator_top DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  bit [63:0]    quarter_sine [0:DEPTH];
  eased_check_t pending_results [$];
  eased_check_t offered;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;
  bit           hold_off = 1'b0;

  curve_row_t directed_rows [NUM_DIRECTED] = '{
    '{'0,               STYLE_LINEAR,     1'b1, '0},
    '{P_ONE,            STYLE_LINEAR,     1'b1, P_ONE},
    '{P_MAX,            STYLE_LINEAR,     1'b1, P_ONE},
    '{17'd12345,        STYLE_LINEAR,     1'b1, 17'd12345},
    '{'0,               STYLE_IN_SINE,    1'b1, '0},
    '{P_ONE,            STYLE_IN_SINE,    1'b1, P_ONE},
    '{P_QUARTER,        STYLE_IN_SINE,    1'b0, '0},
    '{'0,               STYLE_OUT_SINE,   1'b1, '0},
    '{P_ONE,            STYLE_OUT_SINE,   1'b1, P_ONE},
    '{17'd1,            STYLE_OUT_SINE,   1'b0, '0},
    '{'0,               STYLE_INOUT_SINE, 1'b1, '0},
    '{P_HALF,           STYLE_INOUT_SINE, 1'b1, P_HALF},
    '{P_HALF + 17'd1,   STYLE_INOUT_SINE, 1'b0, '0},
    '{P_ONE,            STYLE_INOUT_SINE, 1'b1, P_ONE},
    '{P_HALF,           STYLE_IN_QUAD,    1'b1, P_QUARTER},
    '{17'd1,            STYLE_IN_QUAD,    1'b1, '0},
    '{17'd256,          STYLE_IN_QUAD,    1'b1, 17'd1},
    '{P_HALF - 17'd1,   STYLE_INOUT_QUAD, 1'b0, '0},
    '{P_HALF,           STYLE_INOUT_QUAD, 1'b1, P_HALF},
    '{P_ONE,            STYLE_IN_CUBIC,   1'b1, P_ONE},
    '{P_HALF,           STYLE_IN_CUBIC,   1'b1, P_QUARTER >> 1},
    '{'0,               STYLE_OUT_QUAD,   1'b1, '0},
    '{P_HALF,           STYLE_OUT_QUAD,   1'b1, P_ONE - P_QUARTER},
    '{P_ONE + 17'd1,    STYLE_OUT_QUAD,   1'b1, P_ONE},
    '{P_MAX,            STYLE_IN_SINE,    1'b1, P_ONE}
  };

  // floor(a*b / 2^60), kept to 64 bits
  function automatic bit [63:0] q60_mul(bit [63:0] a, bit [63:0] b);
    bit [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Quarter-wave table: Taylor series in Q60, rounded, clamped, made monotonic
  initial begin : build_sine_table
    bit [63:0] step_q, step_r, x, x2, term, acc, v, prev;
    prev   = 64'd0;
    step_q = HALF_PI_Q60 / DEPTH;
    step_r = HALF_PI_Q60 % DEPTH;
    for (int k = 0; k <= DEPTH; k++) begin
      x    = step_q * 64'(k) + (step_r * 64'(k)) / DEPTH;
      x2   = q60_mul(x, x);
      term = x;
      acc  = x;
      for (int n = 1; n <= 12; n++) begin
        term = q60_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      v = (acc + (64'd1 << (59 - FB))) >> (60 - FB);
      if (v > ONE) v = ONE;
      if (v < prev) v = prev;
      prev = v;
      quarter_sine[k] = v;
    end
  end

  // sine of a phase where ONE is a quarter wave, interpolated between entries
  function automatic bit [63:0] sine_lookup(bit [63:0] phase);
    bit [63:0] pos, idx, frac, lo, hi;
    if (phase >= ONE) return quarter_sine[DEPTH];
    pos  = phase * DEPTH;
    idx  = pos >> FB;
    frac = pos & (ONE - 64'd1);
    if (idx >= DEPTH) return quarter_sine[DEPTH];
    lo = quarter_sine[idx];
    hi = quarter_sine[idx + 1];
    return lo + (((hi - lo) * frac + HALF_LSB) >> FB);
  endfunction

  function automatic bit [63:0] round_mul(bit [63:0] a, bit [63:0] b);
    return (a * b + HALF_LSB) >> FB;
  endfunction

  function automatic logic [FB:0] eased_curve(logic [FB:0] progress, logic [2:0] style);
    bit [63:0] p, q, t, r;
    p = 64'(progress);
    if (p > ONE) p = ONE;
    q = ONE - p;
    r = p;
    case (style)
      STYLE_LINEAR:     r = p;
      STYLE_IN_SINE:    r = ONE - sine_lookup(q);
      STYLE_OUT_SINE:   r = sine_lookup(p);
      STYLE_INOUT_SINE: begin
        t = p << 1;
        if (t <= ONE) r = (ONE - sine_lookup(ONE - t) + 64'd1) >> 1;
        else r = (ONE + sine_lookup(t - ONE) + 64'd1) >> 1;
      end
      STYLE_IN_QUAD:    r = round_mul(p, p);
      STYLE_INOUT_QUAD: begin
        if (p < (ONE >> 1)) r = round_mul(p << 1, p);
        else r = ONE - round_mul(q << 1, q);
      end
      STYLE_IN_CUBIC:   r = round_mul(round_mul(p, p), p);
      STYLE_OUT_QUAD:   r = ONE - round_mul(q, q);
    endcase
    if (r > ONE) r = ONE;
    return r[FB:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int tx_gap();
    if (tx_steady || $urandom_range(0, 2) != 0) return 0;
    return idle_span();
  endfunction

  function automatic logic [FB:0] random_progress();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return (FB + 1)'($urandom_range(0, int'(P_ONE)));
    if (pick < 16) return (FB + 1)'($urandom_range(int'(P_ONE) + 1, int'(P_MAX)));
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'd1;
      2: return P_ONE - 17'd1;
      3: return P_ONE;
      4: return P_HALF - 17'd1;
      5: return P_HALF;
      6: return P_HALF + 17'd1;
      default: return P_QUARTER;
    endcase
  endfunction

  // Returns at the rising edge where the item transfers
  task automatic send_item(logic [FB:0] p, logic [2:0] s, logic [FB:0] eased, int gap);
    @(negedge clk);
    if (gap > 0) begin
      din_if.valid        <= 1'b0;
      din_if.progress     <= (FB + 1)'($urandom);
      din_if.easing_style <= 3'($urandom);
      repeat (gap) @(negedge clk);
    end
    din_if.valid        <= 1'b1;
    din_if.progress     <= p;
    din_if.easing_style <= s;
    offered             <= '{p, s, eased};
    do @(posedge clk); while (!din_if.ready);
  endtask

  // Stop offering and wait until every result is back
  task automatic settle();
    @(negedge clk);
    din_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  initial begin : progress_source
    logic [FB:0] p;
    logic [2:0]  s;
    rst                 = 1'b1;
    din_if.valid        = 1'b0;
    din_if.progress     = '0;
    din_if.easing_style = STYLE_LINEAR;
    offered             = '0;
    // assert reset, then release it on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      p = directed_rows[i].progress;
      s = directed_rows[i].style;
      send_item(p, s, directed_rows[i].typed ? directed_rows[i].eased : eased_curve(p, s),
                tx_gap());
    end
    settle();

    // phase 1: no idling; phase 2: long receiver hold with back-to-back input
    for (int phase = 0; phase < 4; phase++) begin
      tx_steady = (phase == 1 || phase == 2);
      rx_steady = (phase == 1 || phase == 3);
      if (phase == 2) hold_off = 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        p = random_progress();
        s = 3'($urandom_range(0, 7));
        send_item(p, s, eased_curve(p, s), tx_gap());
      end
      settle();
    end

    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin : result_sink
    dout_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        dout_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
        dout_if.ready <= 1'b1;
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        dout_if.ready <= 1'b1;
      end else begin
        dout_if.ready <= 1'b0;
        repeat (idle_span() - 1) @(negedge clk);
      end
    end
  end

  // Result check before the new transfer is queued, so an item never meets itself
  always @(posedge clk) begin : result_check
    eased_check_t head;
    if (!rst) begin
      if (dout_if.valid && dout_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected eased value: expected none, got %0d",
                   $time, dout_if.eased_value);
          mismatches++;
        end else begin
          head = pending_results.pop_front();
          if (dout_if.eased_value !== head.eased) begin
            $display("%0t: eased value (progress %0d style %0d): expected %0d, got %0d",
                     $time, head.progress, head.style, head.eased, dout_if.eased_value);
            mismatches++;
          end
        end
      end
      if (din_if.valid && din_if.ready) pending_results.push_back(offered);
      if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, quiet_cycles, pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== easing_curve_evaluator_top.f =====
sv/ecv_pkg.sv
sv/ecv_if.sv
sv/ecv_sine_rom.sv
sv/ecv_pipe_ctl.sv
sv/easing_curve_evaluator_top.sv
sv/ecv_checker.sv
tb/sv/testbench.sv
